[design/fltw_pkg.sv]
// Shared types and constants for the four-level page table walker.
// Depends on nothing; imported by every module of the walker.
package fltw_pkg;

  localparam int unsigned PaBits = 48;
  localparam int unsigned AddrW = 48;
  localparam int unsigned VaW = 64;
  localparam int unsigned DescW = 64;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [AddrW-1:0] PaMask =
    (PaBits >= AddrW) ? {AddrW{1'b1}} : ((AddrW'(1) << PaBits) - AddrW'(1));

  localparam logic [CfgIdxW-1:0] RegTableBaseLower = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegTableBaseUpper = CfgIdxW'(1);

  typedef enum logic {
    CMD_REQUEST = 1'b0,
    CMD_DESC    = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ACC_READ  = 2'd0,
    ACC_WRITE = 2'd1,
    ACC_FETCH = 2'd2,
    ACC_OTHER = 2'd3
  } access_e;

  typedef enum logic [1:0] {
    FAULT_TRANSLATION = 2'd0,
    FAULT_ACCESS_FLAG = 2'd1,
    FAULT_PERMISSION  = 2'd2
  } fault_kind_e;

  typedef enum logic {
    RES_READ_REQ = 1'b0,
    RES_FINISHED = 1'b1
  } result_kind_e;

  typedef struct packed {
    logic             result_kind;
    logic [AddrW-1:0] read_addr;
    logic [AddrW-1:0] phys_addr;
    logic             fault;
    logic [1:0]       fault_level;
    logic [1:0]       fault_kind;
    logic             fault_on_write;
  } result_t;

endpackage

[design/four_level_page_table_walker_unit.sv]
// Top level of the four-level page table walker: input register, walk control, result register.
// Depends on fltw_pkg, fltw_cfg_regs and fltw_walk_ctrl.
// An accepted transaction goes to the input register, then its result to the result register.
// One transaction per cycle unless the output stalls; the walk control decides each in one pass.
// Memory latency on the descriptor path sets how fast a single walk completes.
// Reset clears both table bases, the walk state and all valid flags.
module four_level_page_table_walker_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        cmd_i,
  input  logic [fltw_pkg::VaW-1:0]    virt_addr_i,
  input  logic [1:0]                  access_type_i,
  input  logic                        user_mode_i,
  input  logic [fltw_pkg::DescW-1:0]  descriptor_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        result_kind_o,
  output logic [fltw_pkg::AddrW-1:0]  read_addr_o,
  output logic [fltw_pkg::AddrW-1:0]  phys_addr_o,
  output logic                        fault_o,
  output logic [1:0]                  fault_level_o,
  output logic [1:0]                  fault_kind_o,
  output logic                        fault_on_write_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [fltw_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [fltw_pkg::AddrW-1:0]  cfg_wdata_i
);
  import fltw_pkg::*;

  logic             s1_valid_q;
  logic             s1_cmd_q;
  logic [VaW-1:0]   s1_va_q;
  logic [1:0]       s1_access_q;
  logic             s1_user_q;
  logic [DescW-1:0] s1_desc_q;
  logic             s1_adv;
  logic             in_accept;

  logic             out_valid_q;
  result_t          out_res_q;

  logic [AddrW-1:0] base_lower;
  logic [AddrW-1:0] base_upper;
  logic             emit;
  result_t          res;

  fltw_cfg_regs u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .base_lower_o (base_lower),
    .base_upper_o (base_upper)
  );

  fltw_walk_ctrl u_walk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (s1_adv),
    .cmd_i         (s1_cmd_q),
    .virt_addr_i   (s1_va_q),
    .access_type_i (s1_access_q),
    .user_mode_i   (s1_user_q),
    .descriptor_i  (s1_desc_q),
    .base_lower_i  (base_lower),
    .base_upper_i  (base_upper),
    .emit_o        (emit),
    .result_o      (res)
  );

  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_cmd_q    <= cmd_i;
      s1_va_q     <= virt_addr_i;
      s1_access_q <= access_type_i;
      s1_user_q   <= user_mode_i;
      s1_desc_q   <= descriptor_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= emit;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && emit) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_kind_o    = out_res_q.result_kind;
  assign read_addr_o      = out_res_q.read_addr;
  assign phys_addr_o      = out_res_q.phys_addr;
  assign fault_o          = out_res_q.fault;
  assign fault_level_o    = out_res_q.fault_level;
  assign fault_kind_o     = out_res_q.fault_kind;
  assign fault_on_write_o = out_res_q.fault_on_write;

endmodule

[design/fltw_cfg_regs.sv]
// Configuration registers of the walker: the two level 0 table bases.
// Depends on fltw_pkg.
module fltw_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [fltw_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [fltw_pkg::AddrW-1:0]   cfg_wdata_i,
  output logic [fltw_pkg::AddrW-1:0]   base_lower_o,
  output logic [fltw_pkg::AddrW-1:0]   base_upper_o
);
  import fltw_pkg::*;

  logic [AddrW-1:0] base_lower_q;
  logic [AddrW-1:0] base_upper_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_lower_q <= '0;
      base_upper_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegTableBaseLower: base_lower_q <= cfg_wdata_i;
        RegTableBaseUpper: base_upper_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign base_lower_o = base_lower_q;
  assign base_upper_o = base_upper_q;

endmodule

[design/fltw_walk_ctrl.sv]
// Walk state and the per-transaction decision: read request, fault or finish.
// Depends on fltw_pkg.
module fltw_walk_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic                       cmd_i,
  input  logic [fltw_pkg::VaW-1:0]   virt_addr_i,
  input  logic [1:0]                 access_type_i,
  input  logic                       user_mode_i,
  input  logic [fltw_pkg::DescW-1:0] descriptor_i,
  input  logic [fltw_pkg::AddrW-1:0] base_lower_i,
  input  logic [fltw_pkg::AddrW-1:0] base_upper_i,
  output logic                       emit_o,
  output fltw_pkg::result_t          result_o
);
  import fltw_pkg::*;

  logic             busy_q, busy_d;
  logic [1:0]       level_q, level_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic [1:0]       access_q, access_d;
  logic             user_q, user_d;

  logic [AddrW-1:0] rd_base;
  logic [AddrW-1:0] rd_va;
  logic [1:0]       rd_level;
  logic [8:0]       rd_index;
  logic [AddrW-1:0] rd_addr;
  logic [1:0]       desc_type;
  logic [AddrW-1:0] desc_oa;
  logic [AddrW-1:0] off_mask;
  logic             ro_ok;
  logic             perm_ok;

  always_comb begin
    unique case (rd_level)
      2'd0:    rd_index = rd_va[47:39];
      2'd1:    rd_index = rd_va[38:30];
      2'd2:    rd_index = rd_va[29:21];
      default: rd_index = rd_va[20:12];
    endcase
    rd_addr = PaMask & (rd_base + {{(AddrW-12){1'b0}}, rd_index, 3'b000});
  end

  assign desc_type = descriptor_i[1:0];
  assign desc_oa = {descriptor_i[AddrW-1:12], 12'h000};
  assign ro_ok = (access_q == ACC_READ) || (access_q == ACC_FETCH);

  always_comb begin
    case (descriptor_i[7:6])
      2'd0:    perm_ok = !user_q;
      2'd1:    perm_ok = 1'b1;
      2'd2:    perm_ok = !user_q && ro_ok;
      default: perm_ok = ro_ok;
    endcase
    case (level_q)
      2'd1:    off_mask = AddrW'(48'h3fff_ffff);
      2'd2:    off_mask = AddrW'(48'h1f_ffff);
      default: off_mask = AddrW'(48'hfff);
    endcase
  end

  always_comb begin
    busy_d   = busy_q;
    level_d  = level_q;
    addr_d   = addr_q;
    access_d = access_q;
    user_d   = user_q;
    emit_o   = 1'b0;
    result_o = '0;
    rd_base  = base_lower_i;
    rd_va    = addr_q;
    rd_level = level_q;

    if (cmd_i == CMD_REQUEST) begin
      access_d = access_type_i;
      user_d   = user_mode_i;
      addr_d   = virt_addr_i[AddrW-1:0];
      level_d  = 2'd0;
      rd_va    = virt_addr_i[AddrW-1:0];
      rd_level = 2'd0;
      emit_o   = 1'b1;
      if (virt_addr_i[VaW-1:AddrW] == '1) begin
        busy_d = 1'b1;
        rd_base = base_upper_i;
        result_o.result_kind = RES_READ_REQ;
        result_o.read_addr = rd_addr;
      end else if (virt_addr_i[VaW-1:AddrW] == '0) begin
        busy_d = 1'b1;
        rd_base = base_lower_i;
        result_o.result_kind = RES_READ_REQ;
        result_o.read_addr = rd_addr;
      end else begin
        busy_d = 1'b0;
        result_o.result_kind = RES_FINISHED;
        result_o.fault = 1'b1;
        result_o.fault_level = 2'd0;
        result_o.fault_kind = FAULT_TRANSLATION;
        result_o.fault_on_write = (access_type_i == ACC_WRITE);
      end
    end else if (busy_q) begin
      emit_o = 1'b1;
      result_o.fault_level = level_q;
      result_o.fault_on_write = (access_q == ACC_WRITE);
      if (desc_type == 2'd0 || desc_type == 2'd2 ||
          (desc_type == 2'd1 && (level_q == 2'd0 || level_q == 2'd3))) begin
        busy_d = 1'b0;
        result_o.result_kind = RES_FINISHED;
        result_o.fault = 1'b1;
        result_o.fault_kind = FAULT_TRANSLATION;
      end else if (desc_type == 2'd3 && level_q != 2'd3) begin
        level_d = level_q + 2'd1;
        rd_base = desc_oa;
        rd_level = level_q + 2'd1;
        result_o = '0;
        result_o.result_kind = RES_READ_REQ;
        result_o.read_addr = rd_addr;
      end else if (!descriptor_i[10]) begin
        busy_d = 1'b0;
        result_o.result_kind = RES_FINISHED;
        result_o.fault = 1'b1;
        result_o.fault_kind = FAULT_ACCESS_FLAG;
      end else if (!perm_ok) begin
        busy_d = 1'b0;
        result_o.result_kind = RES_FINISHED;
        result_o.fault = 1'b1;
        result_o.fault_kind = FAULT_PERMISSION;
      end else begin
        busy_d = 1'b0;
        result_o = '0;
        result_o.result_kind = RES_FINISHED;
        result_o.phys_addr = PaMask & (desc_oa | (addr_q & off_mask));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      level_q  <= 2'd0;
      addr_q   <= '0;
      access_q <= 2'd0;
      user_q   <= 1'b0;
    end else if (step_i) begin
      busy_q   <= busy_d;
      level_q  <= level_d;
      addr_q   <= addr_d;
      access_q <= access_d;
      user_q   <= user_d;
    end
  end

endmodule

[dv/fltw_walk_checker.sv]
// Descriptor encodings and the result checker for the four-level page table walker bench.
// The checker predicts every walk result from the observed transactions and compares them.
// Depends on fltw_pkg; the bench top imports fltw_dv_pkg from this file.
package fltw_dv_pkg;

  localparam int unsigned AfBit = 10;
  localparam int unsigned ApLsb = 6;

  typedef enum logic [1:0] {
    DESC_INVALID  = 2'd0,
    DESC_BLOCK    = 2'd1,
    DESC_RESERVED = 2'd2,
    DESC_TABLE    = 2'd3
  } desc_type_e;

  typedef enum logic [1:0] {
    AP_PRIV_RW = 2'd0,
    AP_ALL_RW  = 2'd1,
    AP_PRIV_RO = 2'd2,
    AP_ALL_RO  = 2'd3
  } ap_e;

endpackage

module fltw_walk_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_o,
  input  logic                          cmd_i,
  input  logic [fltw_pkg::VaW-1:0]      virt_addr_i,
  input  logic [1:0]                    access_type_i,
  input  logic                          user_mode_i,
  input  logic [fltw_pkg::DescW-1:0]    descriptor_i,
  input  logic                          out_valid_o,
  input  logic                          out_stall_i,
  input  logic                          result_kind_o,
  input  logic [fltw_pkg::AddrW-1:0]    read_addr_o,
  input  logic [fltw_pkg::AddrW-1:0]    phys_addr_o,
  input  logic                          fault_o,
  input  logic [1:0]                    fault_level_o,
  input  logic [1:0]                    fault_kind_o,
  input  logic                          fault_on_write_o,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_o,
  input  logic [fltw_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [fltw_pkg::AddrW-1:0]    cfg_wdata_i,
  output int                            fail_count,
  output int                            results_due,
  output int                            results_checked
);
  import fltw_pkg::*;
  import fltw_dv_pkg::*;

  logic [AddrW-1:0] table_base_lo = '0;
  logic [AddrW-1:0] table_base_hi = '0;
  logic             walk_active = 1'b0;
  logic [1:0]       cur_level = 2'd0;
  logic [AddrW-1:0] walk_va = '0;
  access_e          walk_access = ACC_READ;
  logic             walk_user = 1'b0;
  result_t          walk_results_due[$];

  initial begin
    fail_count = 0;
    results_due = 0;
    results_checked = 0;
  end

  function automatic logic [8:0] va_index(input logic [AddrW-1:0] va, input logic [1:0] level);
    return 9'(va >> (39 - 9 * int'(level)));
  endfunction

  function automatic result_t read_request(input logic [AddrW-1:0] base, input logic [1:0] level);
    result_t r;
    r = '0;
    r.result_kind = RES_READ_REQ;
    r.read_addr = (base + AddrW'(va_index(walk_va, level)) * AddrW'(8)) & PaMask;
    return r;
  endfunction

  function automatic result_t fault_result(input fault_kind_e kind);
    result_t r;
    r = '0;
    r.result_kind = RES_FINISHED;
    r.fault = 1'b1;
    r.fault_level = cur_level;
    r.fault_kind = kind;
    r.fault_on_write = (walk_access == ACC_WRITE);
    return r;
  endfunction

  function automatic result_t done_result(input logic [AddrW-1:0] pa);
    result_t r;
    r = '0;
    r.result_kind = RES_FINISHED;
    r.phys_addr = pa & PaMask;
    return r;
  endfunction

  function automatic logic ap_grants(input ap_e ap);
    logic read_like;
    read_like = (walk_access == ACC_READ) || (walk_access == ACC_FETCH);
    case (ap)
      AP_PRIV_RW: return !walk_user;
      AP_ALL_RW:  return 1'b1;
      AP_PRIV_RO: return !walk_user && read_like;
      default:    return read_like;
    endcase
  endfunction

  task automatic predict_walk_step();
    desc_type_e       dtype;
    logic [AddrW-1:0] oa;
    logic [AddrW-1:0] offset_mask;
    if (cmd_e'(cmd_i) == CMD_REQUEST) begin
      walk_va = virt_addr_i[AddrW-1:0];
      walk_access = access_e'(access_type_i);
      walk_user = user_mode_i;
      cur_level = 2'd0;
      walk_active = 1'b1;
      if (virt_addr_i[63:48] == 16'hffff) begin
        walk_results_due.push_back(read_request(table_base_hi, 2'd0));
      end else if (virt_addr_i[63:48] == 16'h0000) begin
        walk_results_due.push_back(read_request(table_base_lo, 2'd0));
      end else begin
        walk_active = 1'b0;
        walk_results_due.push_back(fault_result(FAULT_TRANSLATION));
      end
    end else if (walk_active) begin
      dtype = desc_type_e'(descriptor_i[1:0]);
      oa = {descriptor_i[47:12], 12'h000};
      walk_active = 1'b0;
      if (dtype == DESC_TABLE && cur_level != 2'd3) begin
        walk_active = 1'b1;
        cur_level = cur_level + 2'd1;
        walk_results_due.push_back(read_request(oa, cur_level));
      end else if (dtype == DESC_INVALID || dtype == DESC_RESERVED ||
                   (dtype == DESC_BLOCK && (cur_level == 2'd0 || cur_level == 2'd3))) begin
        walk_results_due.push_back(fault_result(FAULT_TRANSLATION));
      end else if (!descriptor_i[AfBit]) begin
        walk_results_due.push_back(fault_result(FAULT_ACCESS_FLAG));
      end else if (!ap_grants(ap_e'(descriptor_i[ApLsb +: 2]))) begin
        walk_results_due.push_back(fault_result(FAULT_PERMISSION));
      end else begin
        case (cur_level)
          2'd1: offset_mask = 48'h0000_3fff_ffff;
          2'd2: offset_mask = 48'h0000_001f_ffff;
          default: offset_mask = 48'h0000_0000_0fff;
        endcase
        walk_results_due.push_back(done_result(oa | (walk_va & offset_mask)));
      end
    end
  endtask

  function automatic void check_field(input string field, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    end
  endfunction

  task automatic check_result();
    result_t want;
    if (walk_results_due.size() == 0) begin
      fail_count++;
      $display("%0t: unexpected result, expected none, actual kind %0d read %h phys %h fault %0d",
               $time, result_kind_o, read_addr_o, phys_addr_o, fault_o);
    end else begin
      want = walk_results_due.pop_front();
      check_field("result_kind", 64'(want.result_kind), 64'(result_kind_o));
      check_field("read_addr", 64'(want.read_addr), 64'(read_addr_o));
      check_field("phys_addr", 64'(want.phys_addr), 64'(phys_addr_o));
      check_field("fault", 64'(want.fault), 64'(fault_o));
      check_field("fault_level", 64'(want.fault_level), 64'(fault_level_o));
      check_field("fault_kind", 64'(want.fault_kind), 64'(fault_kind_o));
      check_field("fault_on_write", 64'(want.fault_on_write), 64'(fault_on_write_o));
      results_checked++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_base_lo = '0;
      table_base_hi = '0;
      walk_active = 1'b0;
      cur_level = 2'd0;
      walk_va = '0;
      walk_access = ACC_READ;
      walk_user = 1'b0;
      walk_results_due.delete();
      results_due = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          RegTableBaseLower: table_base_lo = cfg_wdata_i;
          RegTableBaseUpper: table_base_hi = cfg_wdata_i;
          default: ;
        endcase
      end
      if (out_valid_o && !out_stall_i) begin
        check_result();
      end
      if (in_valid_i && !in_stall_o) begin
        predict_walk_step();
      end
      results_due = walk_results_due.size();
    end
  end

endmodule

[dv/tb_four_level_page_table_walker_unit.sv]
// Bench top for the four-level page table walker: clock, reset, walk stimulus and verdict.
// Drives directed and random translation walks under several table bases with random stalls.
// Depends on fltw_pkg, fltw_dv_pkg and fltw_walk_checker.
module tb_four_level_page_table_walker_unit;
  import fltw_pkg::*;
  import fltw_dv_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int PhaseItems = 500;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_HALF
  } stall_mode_e;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic                 cmd_i;
  logic [VaW-1:0]       virt_addr_i;
  logic [1:0]           access_type_i;
  logic                 user_mode_i;
  logic [DescW-1:0]     descriptor_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic                 result_kind_o;
  logic [AddrW-1:0]     read_addr_o;
  logic [AddrW-1:0]     phys_addr_o;
  logic                 fault_o;
  logic [1:0]           fault_level_o;
  logic [1:0]           fault_kind_o;
  logic                 fault_on_write_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i;
  logic [AddrW-1:0]     cfg_wdata_i;

  int fail_count;
  int results_due;
  int results_checked;
  int cycle_count;
  int items_sent = 0;
  int strays_sent = 0;
  int settings_used = 0;
  int burst_left = 0;
  bit hold_request = 1'b0;

  always #5 clk_i = ~clk_i;

  four_level_page_table_walker_unit uut (.*);

  fltw_walk_checker u_walk_checker (.*);

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pick_va();
    logic [63:0] va;
    va = rand64();
    case ($urandom_range(0, 19))
      0: va[63:48] = 16'($urandom);
      1, 2, 3, 4, 5, 6, 7, 8, 9: va[63:48] = 16'hffff;
      default: va[63:48] = 16'h0000;
    endcase
    if ($urandom_range(0, 15) == 0) begin
      va[47:0] = $urandom_range(0, 1) ? '1 : '0;
    end
    return va;
  endfunction

  function automatic logic [63:0] make_desc(input desc_type_e dtype, input logic af,
                                            input ap_e ap);
    logic [63:0] d;
    d = rand64();
    d[1:0] = dtype;
    d[AfBit] = af;
    d[ApLsb +: 2] = ap;
    return d;
  endfunction

  task automatic send_item(input cmd_e cmd, input logic [63:0] va, input access_e acc,
                           input logic user, input logic [63:0] desc);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      repeat ($urandom_range(1, 12)) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    cmd_i <= cmd;
    virt_addr_i <= va;
    access_type_i <= acc;
    user_mode_i <= user;
    descriptor_i <= desc;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (results_due != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_table_bases(input logic [AddrW-1:0] lower, input logic [AddrW-1:0] upper);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= RegTableBaseLower;
    cfg_wdata_i <= lower;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_index_i <= RegTableBaseUpper;
    cfg_wdata_i <= upper;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  task automatic run_walk();
    logic [63:0] va;
    logic [63:0] d;
    access_e     acc;
    logic        user;
    int          leaf_level;
    va = pick_va();
    acc = access_e'($urandom_range(0, 3));
    user = 1'($urandom_range(0, 1));
    send_item(CMD_REQUEST, va, acc, user, rand64());
    if (va[63:48] != 16'h0000 && va[63:48] != 16'hffff) return;
    leaf_level = $urandom_range(0, 3);
    for (int lvl = 0; lvl < leaf_level; lvl++) begin
      if ($urandom_range(0, 29) == 0) return;
      send_item(CMD_DESC, rand64(), access_e'($urandom_range(0, 3)),
                1'($urandom_range(0, 1)),
                make_desc(DESC_TABLE, 1'($urandom_range(0, 1)), ap_e'($urandom_range(0, 3))));
    end
    case ($urandom_range(0, 9))
      0: d = rand64();
      1: begin
        d = rand64();
        d[0] = 1'b0;
      end
      default: d = make_desc((leaf_level == 3) ? DESC_TABLE : DESC_BLOCK,
                             $urandom_range(0, 7) != 0, ap_e'($urandom_range(0, 3)));
    endcase
    send_item(CMD_DESC, rand64(), access_e'($urandom_range(0, 3)),
              1'($urandom_range(0, 1)), d);
  endtask

  task automatic run_phase(input logic [AddrW-1:0] lower, input logic [AddrW-1:0] upper,
                           input bit long_hold);
    int target;
    drain();
    set_table_bases(lower, upper);
    if (long_hold) hold_request = 1'b1;
    target = items_sent - strays_sent + PhaseItems;
    while (items_sent - strays_sent < target) begin
      case ($urandom_range(0, 19))
        0, 1: begin
          send_item(CMD_DESC, rand64(), access_e'($urandom_range(0, 3)),
                    1'($urandom_range(0, 1)), rand64());
          strays_sent++;
        end
        2: send_item(cmd_e'($urandom_range(0, 1)), rand64(), access_e'($urandom_range(0, 3)),
                     1'($urandom_range(0, 1)), rand64());
        default: run_walk();
      endcase
    end
  endtask

  initial begin : watchdog
    for (cycle_count = 0; cycle_count < CycleLimit; cycle_count++) @(posedge clk_i);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : receiver
    stall_mode_e mode;
    int          run_len;
    int          hold_cycles;
    bit          long_hold_done;
    long_hold_done = 1'b0;
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_request && !long_hold_done) begin
        long_hold_done = 1'b1;
        for (hold_cycles = 0; hold_cycles < 300; hold_cycles++) begin
          @(negedge clk_i);
          out_stall_i <= 1'b1;
        end
      end else begin
        mode = stall_mode_e'($urandom_range(0, 3));
        run_len = $urandom_range(5, 60);
        repeat (run_len) begin
          @(negedge clk_i);
          case (mode)
            STALL_NONE:  out_stall_i <= 1'b0;
            STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
            default:     out_stall_i <= 1'($urandom_range(0, 1));
          endcase
        end
      end
    end
  end

  initial begin : stimulus
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    cmd_i = CMD_REQUEST;
    virt_addr_i = '0;
    access_type_i = ACC_READ;
    user_mode_i = 1'b0;
    descriptor_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = RegTableBaseLower;
    cfg_wdata_i = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    set_table_bases('1, '0);
    send_item(CMD_DESC, '1, ACC_OTHER, 1'b1, '1);
    strays_sent++;
    send_item(CMD_REQUEST, 64'h0, ACC_READ, 1'b0, '0);
    repeat (4) send_item(CMD_DESC, '0, ACC_READ, 1'b0, '1);
    send_item(CMD_REQUEST, '1, ACC_WRITE, 1'b1, '0);
    send_item(CMD_DESC, '0, ACC_WRITE, 1'b1, 64'h0);
    send_item(CMD_REQUEST, 64'h0001_0000_0000_0000, ACC_FETCH, 1'b0, '0);
    send_item(CMD_REQUEST, 64'hfffe_ffff_ffff_ffff, ACC_OTHER, 1'b1, '0);
    send_item(CMD_REQUEST, 64'hffff_0000_0000_0000, ACC_READ, 1'b1, '0);
    send_item(CMD_DESC, '0, ACC_READ, 1'b1, 64'h1);
    send_item(CMD_REQUEST, 64'h0000_ffff_ffff_ffff, ACC_OTHER, 1'b0, '0);
    send_item(CMD_DESC, '0, ACC_READ, 1'b0, 64'h3);
    send_item(CMD_DESC, '0, ACC_READ, 1'b0, 64'h2);
    send_item(CMD_REQUEST, 64'h0000_7fff_ffff_f123, ACC_WRITE, 1'b1, '0);
    send_item(CMD_DESC, '0, ACC_READ, 1'b0, 64'h3);
    send_item(CMD_DESC, '0, ACC_READ, 1'b0, 64'h401);
    send_item(CMD_REQUEST, 64'h0000_1234_5678_9abc, ACC_WRITE, 1'b0, '0);
    send_item(CMD_DESC, '0, ACC_READ, 1'b0, 64'h3);
    send_item(CMD_DESC, '0, ACC_READ, 1'b0, 64'h3);
    send_item(CMD_DESC, '0, ACC_READ, 1'b0, 64'h0000_0000_0020_0001);
    send_item(CMD_REQUEST, 64'hffff_8000_0000_0fff, ACC_OTHER, 1'b0, '0);
    send_item(CMD_REQUEST, 64'h0000_0000_dead_beef, ACC_FETCH, 1'b1, '0);
    send_item(CMD_DESC, '0, ACC_READ, 1'b0, 64'hffff_ffff_ffff_f003);
    send_item(CMD_DESC, '0, ACC_READ, 1'b0, 64'hffff_ffff_c000_04c1);

    run_phase(48'(rand64()), 48'(rand64()), 1'b1);
    run_phase('0, '1, 1'b0);
    run_phase('1, 48'(rand64()), 1'b0);
    run_phase(48'(rand64()), '0, 1'b0);
    drain();

    $display("Covered %0d transactions (%0d stray descriptors) under %0d table base settings.",
             items_sent, strays_sent, settings_used);
    $display("Checked %0d walk results against the prediction.", results_checked);
    if (fail_count == 0 && results_due == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
